// ----- rtl/tcc_pkg.sv -----
// Shared types and constants for the text console cursor engine.
package tcc_pkg;

    localparam int CHAR_W     = 8;
    localparam int IDX_W      = 11;
    localparam int ROW_OUT_W  = 5;
    localparam int COL_OUT_W  = 7;
    localparam int CELL_W     = 16;
    localparam int COLOR_W    = 8;
    localparam int LE_W       = 7;
    localparam int LE_MAX     = 127;

    localparam logic [CHAR_W-1:0]  CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0]  CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0]  CH_SPACE     = 8'd32;
    localparam logic [CELL_W-1:0]  CELL_RESET   = 16'h0720;
    localparam logic [COLOR_W-1:0] COLOR_RESET  = 8'd7;

    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_SCROLL,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic sweep_clear;
        logic sweep_scroll;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic sweep_last;
        logic needs_scroll;
        logic out_free;
    } status_t;

endpackage

// ----- rtl/text_console_cursor_engine.sv -----
// Top level of the character-cell text console with cursor tracking.
//
//   channel   direction  handshake            payload
//   in        receive    in_valid / in_stall  op, char_code, cell_index
//   out       send       out_valid / out_stall cursor_row_out, cursor_col_out, cell_data
//   cfg       receive    cfg_wr_en            cfg_wr_data (text_color)
//
// A put or a read accesses the screen store in ST_EXEC, where a put also moves the
// cursor, then loads the result register in ST_DONE. A newline or wrap on the last
// row adds a scroll copy through the screen store, which reads one row ahead while
// it writes the previous cell. After reset a clearing pass fills the store; in_stall
// stays high meanwhile. A held result keeps the next transaction waiting in ST_DONE.
module text_console_cursor_engine #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [tcc_pkg::COLOR_W-1:0]       cfg_wr_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              op,
    input  logic [tcc_pkg::CHAR_W-1:0]        char_code,
    input  logic [tcc_pkg::IDX_W-1:0]         cell_index,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [tcc_pkg::ROW_OUT_W-1:0]     cursor_row_out,
    output logic [tcc_pkg::COL_OUT_W-1:0]     cursor_col_out,
    output logic [tcc_pkg::CELL_W-1:0]        cell_data
);

    tcc_pkg::cmd_t    cmd;
    tcc_pkg::status_t status;

    tcc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    tcc_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .op             (op),
        .char_code      (char_code),
        .cell_index     (cell_index),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .cursor_row_out (cursor_row_out),
        .cursor_col_out (cursor_col_out),
        .cell_data      (cell_data)
    );

endmodule

// ----- rtl/tcc_ctrl.sv -----
// Sequencing state machine for the text console cursor engine.
module tcc_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  tcc_pkg::status_t status,
    output tcc_pkg::cmd_t    cmd
);

    tcc_pkg::state_t state_reg;
    tcc_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tcc_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            tcc_pkg::ST_CLEAR:
            begin
                cmd.sweep_clear = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = tcc_pkg::ST_IDLE;
                end
            end
            tcc_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = tcc_pkg::ST_EXEC;
                end
            end
            tcc_pkg::ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = status.needs_scroll ? tcc_pkg::ST_SCROLL : tcc_pkg::ST_DONE;
            end
            tcc_pkg::ST_SCROLL:
            begin
                cmd.sweep_scroll = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = tcc_pkg::ST_DONE;
                end
            end
            tcc_pkg::ST_DONE:
            begin
                // hand the result over and take the next transaction in the same cycle
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    in_stall     = 1'b0;
                    if (in_valid)
                    begin
                        cmd.capture = 1'b1;
                        state_next  = tcc_pkg::ST_EXEC;
                    end
                    else
                    begin
                        state_next = tcc_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = tcc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/tcc_datapath.sv -----
// Screen store, cursor, line-end table and result register of the text console.
module tcc_datapath #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  tcc_pkg::cmd_t                     cmd,
    output tcc_pkg::status_t                  status,
    input  logic                              cfg_wr_en,
    input  logic [tcc_pkg::COLOR_W-1:0]       cfg_wr_data,
    input  logic                              op,
    input  logic [tcc_pkg::CHAR_W-1:0]        char_code,
    input  logic [tcc_pkg::IDX_W-1:0]         cell_index,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [tcc_pkg::ROW_OUT_W-1:0]     cursor_row_out,
    output logic [tcc_pkg::COL_OUT_W-1:0]     cursor_col_out,
    output logic [tcc_pkg::CELL_W-1:0]        cell_data
);

    localparam int CELLS   = ROWS * COLUMNS;
    localparam int AW      = $clog2(CELLS);
    localparam int CNT_W   = $clog2(CELLS + 1);
    localparam int RW      = $clog2(ROWS);
    localparam int CW      = $clog2(COLUMNS);
    localparam int LE_WRAP = (COLUMNS > tcc_pkg::LE_MAX) ? tcc_pkg::LE_MAX : COLUMNS;

    logic [tcc_pkg::CELL_W-1:0] screen_mem [CELLS];

    logic                          op_reg;
    logic [tcc_pkg::CHAR_W-1:0]    char_reg;
    logic [AW-1:0]                 idx_reg;
    logic                          idx_ok_reg;
    logic [RW-1:0]                 row_reg, row_next;
    logic [CW-1:0]                 col_reg, col_next;
    logic [tcc_pkg::LE_W-1:0]      line_end_reg [ROWS];
    logic [tcc_pkg::COLOR_W-1:0]   color_reg;
    logic [CNT_W-1:0]              sweep_reg, sweep_next;
    logic [tcc_pkg::CELL_W-1:0]    rdata_reg;
    logic                          out_valid_reg, out_valid_next;
    logic [tcc_pkg::ROW_OUT_W-1:0] row_out_reg;
    logic [tcc_pkg::COL_OUT_W-1:0] col_out_reg;
    logic [tcc_pkg::CELL_W-1:0]    cell_out_reg;

    logic [tcc_pkg::IDX_W+1:0]     idx_ext;
    logic                          is_nl, is_bs, at_last_col, at_last_row, at_origin;
    logic [RW-1:0]                 prev_row;
    logic [tcc_pkg::LE_W-1:0]      le_prev;
    logic [CW-1:0]                 bs_col;
    logic                          le_we;
    logic [tcc_pkg::LE_W-1:0]      le_val;
    logic [RW-1:0]                 wr_row;
    logic [CW-1:0]                 wr_col;
    logic [tcc_pkg::CHAR_W-1:0]    wr_char;
    logic                          put_we;
    logic [CNT_W:0]                scroll_raddr;
    logic                          mem_we, mem_re;
    logic [AW-1:0]                 mem_waddr, mem_raddr;
    logic [tcc_pkg::CELL_W-1:0]    mem_wdata, blank_cell;

    assign idx_ext    = (tcc_pkg::IDX_W+2)'(cell_index);
    assign blank_cell = {color_reg, tcc_pkg::CH_SPACE};

    // capture the transaction
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg     <= op;
            char_reg   <= char_code;
            idx_reg    <= idx_ext[AW-1:0];
            idx_ok_reg <= (32'(cell_index) < CELLS);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_reg <= tcc_pkg::COLOR_RESET;
        end
        else if (cfg_wr_en)
        begin
            color_reg <= cfg_wr_data;
        end
    end

    // put step: cursor movement, line-end record and cell write
    always_comb
    begin
        is_nl       = (char_reg == tcc_pkg::CH_NEWLINE);
        is_bs       = (char_reg == tcc_pkg::CH_BACKSPACE);
        at_last_col = (col_reg == CW'(COLUMNS - 1));
        at_last_row = (row_reg == RW'(ROWS - 1));
        at_origin   = (col_reg == '0) && (row_reg == '0);
        prev_row    = row_reg - 1'b1;
        le_prev     = line_end_reg[prev_row];
        bs_col      = (int'(le_prev) > COLUMNS - 1) ? CW'(COLUMNS - 1) : CW'(le_prev);

        row_next = row_reg;
        col_next = col_reg;
        le_we    = 1'b0;
        le_val   = tcc_pkg::LE_W'(col_reg);
        wr_row   = row_reg;
        wr_col   = col_reg;
        wr_char  = char_reg;
        put_we   = 1'b0;

        if (op_reg == tcc_pkg::OP_PUT)
        begin
            if (is_bs)
            begin
                if (!at_origin)
                begin
                    if (col_reg == '0)
                    begin
                        row_next = prev_row;
                        col_next = bs_col;
                    end
                    else
                    begin
                        col_next = col_reg - 1'b1;
                    end
                    wr_row  = row_next;
                    wr_col  = col_next;
                    wr_char = tcc_pkg::CH_SPACE;
                    put_we  = 1'b1;
                end
            end
            else
            begin
                put_we = !is_nl;
                if (is_nl || at_last_col)
                begin
                    le_we    = 1'b1;
                    le_val   = is_nl ? tcc_pkg::LE_W'(col_reg) : tcc_pkg::LE_W'(LE_WRAP);
                    col_next = '0;
                    if (!at_last_row)
                    begin
                        row_next = row_reg + 1'b1;
                    end
                end
                else
                begin
                    col_next = col_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
            for (int i = 0; i < ROWS; i++)
            begin
                line_end_reg[i] <= '0;
            end
        end
        else if (cmd.exec)
        begin
            row_reg <= row_next;
            col_reg <= col_next;
            if (le_we)
            begin
                line_end_reg[row_reg] <= le_val;
            end
        end
    end

    // sweep counter for the clearing pass and the scroll copy
    assign sweep_next = (cmd.sweep_clear || cmd.sweep_scroll) ? sweep_reg + 1'b1 : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_reg <= '0;
        end
        else
        begin
            sweep_reg <= sweep_next;
        end
    end

    // scroll reads one row ahead and writes the previous sweep slot
    assign scroll_raddr = (CNT_W+1)'(sweep_reg) + (CNT_W+1)'(COLUMNS);

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = AW'(int'(wr_row) * COLUMNS + int'(wr_col));
        mem_wdata = {color_reg, wr_char};
        mem_re    = 1'b0;
        mem_raddr = idx_reg;
        if (cmd.sweep_clear)
        begin
            mem_we    = 1'b1;
            mem_waddr = sweep_reg[AW-1:0];
            mem_wdata = tcc_pkg::CELL_RESET;
        end
        else if (cmd.sweep_scroll)
        begin
            mem_re    = (32'(scroll_raddr) < CELLS);
            mem_raddr = scroll_raddr[AW-1:0];
            mem_we    = (sweep_reg != '0);
            mem_waddr = AW'(sweep_reg - 1'b1);
            mem_wdata = (32'(sweep_reg) <= CELLS - COLUMNS) ? rdata_reg : blank_cell;
        end
        else if (cmd.exec)
        begin
            mem_we = put_we;
            mem_re = (op_reg == tcc_pkg::OP_READ);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            screen_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= screen_mem[mem_raddr];
        end
    end

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            row_out_reg  <= tcc_pkg::ROW_OUT_W'(row_reg);
            col_out_reg  <= tcc_pkg::COL_OUT_W'(col_reg);
            cell_out_reg <= ((op_reg == tcc_pkg::OP_READ) && idx_ok_reg) ? rdata_reg : '0;
        end
    end

    assign status.out_free     = !out_valid_reg || !out_stall;
    assign status.needs_scroll = (op_reg == tcc_pkg::OP_PUT) && !is_bs && at_last_row
                                 && (is_nl || at_last_col);
    assign status.sweep_last   = cmd.sweep_clear ? (sweep_reg == CNT_W'(CELLS - 1))
                                                 : (sweep_reg == CNT_W'(CELLS));

    assign out_valid      = out_valid_reg;
    assign cursor_row_out = row_out_reg;
    assign cursor_col_out = col_out_reg;
    assign cell_data      = cell_out_reg;

endmodule

// ----- rtl/tcc_checker.sv -----
// Port-level checks for the text console, bound to the top level.
module tcc_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [tcc_pkg::ROW_OUT_W-1:0] cursor_row_out,
    input logic [tcc_pkg::COL_OUT_W-1:0] cursor_col_out,
    input logic [tcc_pkg::CELL_W-1:0]    cell_data
);

    // one transaction at a time: an accept is followed by a busy cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input accepted on consecutive cycles");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (32'(cursor_row_out) < ROWS))
        else $error("cursor row out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (32'(cursor_col_out) < COLUMNS))
        else $error("cursor column out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(cursor_row_out)
            && $stable(cursor_col_out) && $stable(cell_data))
        else $error("stalled result changed");

endmodule

bind text_console_cursor_engine tcc_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcc_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .cursor_row_out (cursor_row_out),
    .cursor_col_out (cursor_col_out),
    .cell_data      (cell_data)
);

// ----- test/console_checker.sv -----
// Checker for the text console: watches all channels, predicts each result, compares.
module console_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [tcc_pkg::COLOR_W-1:0]  cfg_wr_data,
    input  logic                         in_valid,
    input  logic                         in_stall,
    input  logic                         op,
    input  logic [tcc_pkg::CHAR_W-1:0]   char_code,
    input  logic [tcc_pkg::IDX_W-1:0]    cell_index,
    input  logic                         out_valid,
    input  logic                         out_stall,
    input  logic [tcc_pkg::ROW_OUT_W-1:0] cursor_row_out,
    input  logic [tcc_pkg::COL_OUT_W-1:0] cursor_col_out,
    input  logic [tcc_pkg::CELL_W-1:0]   cell_data,
    output int                           mismatches,
    output int                           results_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import tcc_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;

    typedef struct packed {
        logic [ROW_OUT_W-1:0] row;
        logic [COL_OUT_W-1:0] col;
        logic [CELL_W-1:0]    cell_word;
    } cursor_report_t;

    logic [CELL_W-1:0]  glyph_mem [CELLS];
    int unsigned        row_pos;
    int unsigned        col_pos;
    int unsigned        row_end_col [ROWS];
    logic [COLOR_W-1:0] attr;
    cursor_report_t     reports_due [$];

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("%0t ns mismatch: %s", $time, what);
    endtask

    function automatic void shift_rows_up();
        for (int i = 0; i + COLUMNS < CELLS; i++)
            glyph_mem[i] = glyph_mem[i + COLUMNS];
        for (int i = CELLS - COLUMNS; i < CELLS; i++)
            glyph_mem[i] = {attr, CH_SPACE};
    endfunction

    function automatic void advance_line();
        row_end_col[row_pos] = (col_pos > LE_MAX) ? LE_MAX : col_pos;
        row_pos++;
        if (row_pos >= ROWS)
        begin
            shift_rows_up();
            row_pos = ROWS - 1;
        end
        col_pos = 0;
    endfunction

    function automatic void step_back();
        if (col_pos == 0)
        begin
            if (row_pos == 0)
                return;
            row_pos--;
            // restore the recorded line end, clamped to the last column
            col_pos = (row_end_col[row_pos] > COLUMNS - 1) ? COLUMNS - 1
                                                           : row_end_col[row_pos];
        end
        else
        begin
            col_pos--;
        end
        glyph_mem[row_pos * COLUMNS + col_pos] = {attr, CH_SPACE};
    endfunction

    function automatic cursor_report_t apply_console_input(
        input logic                op_v,
        input logic [CHAR_W-1:0]   ch,
        input logic [IDX_W-1:0]    idx
    );
        cursor_report_t    r;
        logic [CELL_W-1:0] data;
        data = '0;
        if (op_v == OP_READ)
        begin
            if (idx < CELLS)
                data = glyph_mem[idx];
        end
        else if (ch == CH_NEWLINE)
        begin
            advance_line();
        end
        else if (ch == CH_BACKSPACE)
        begin
            step_back();
        end
        else
        begin
            glyph_mem[row_pos * COLUMNS + col_pos] = {attr, ch};
            col_pos++;
            if (col_pos >= COLUMNS)
                advance_line();
        end
        r.row       = row_pos[ROW_OUT_W-1:0];
        r.col       = col_pos[COL_OUT_W-1:0];
        r.cell_word = data;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        cursor_report_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < CELLS; i++)
                glyph_mem[i] = CELL_RESET;
            for (int i = 0; i < ROWS; i++)
                row_end_col[i] = 0;
            row_pos = 0;
            col_pos = 0;
            attr = COLOR_RESET;
            reports_due.delete();
            mismatches = 0;
            results_pending <= 0;
        end
        else
        begin
            if (cfg_wr_en)
                attr = cfg_wr_data;
            if (in_valid && !in_stall)
                reports_due.push_back(apply_console_input(op, char_code, cell_index));
            if (out_valid && !out_stall)
            begin
                if (reports_due.size() == 0)
                begin
                    report_mismatch("result with no transaction outstanding");
                end
                else
                begin
                    want = reports_due.pop_front();
                    if (cursor_row_out !== want.row)
                        report_mismatch($sformatf("cursor_row_out %0d, expected %0d",
                                                  cursor_row_out, want.row));
                    if (cursor_col_out !== want.col)
                        report_mismatch($sformatf("cursor_col_out %0d, expected %0d",
                                                  cursor_col_out, want.col));
                    if (cell_data !== want.cell_word)
                        report_mismatch($sformatf("cell_data %h, expected %h",
                                                  cell_data, want.cell_word));
                end
            end
            results_pending <= reports_due.size();
        end
    end

endmodule

// ----- test/tb.sv -----
// Testbench top for the text console: clock, reset, stimulus and verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tcc_pkg::*;

    localparam int COLUMNS     = 80;
    localparam int ROWS        = 25;
    localparam int CELLS       = COLUMNS * ROWS;
    localparam int PHASE_ITEMS = 160;
    localparam int DRAIN_LIMIT = 200000;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [COLOR_W-1:0]   cfg_wr_data;
    logic                 in_valid;
    logic                 in_stall;
    logic                 op;
    logic [CHAR_W-1:0]    char_code;
    logic [IDX_W-1:0]     cell_index;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [ROW_OUT_W-1:0] cursor_row_out;
    logic [COL_OUT_W-1:0] cursor_col_out;
    logic [CELL_W-1:0]    cell_data;

    logic        idling_on = 1'b1;
    int unsigned stall_left = 0;
    int          mismatches;
    int          results_pending;

    always #6 clk = ~clk;

    text_console_cursor_engine #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .op             (op),
        .char_code      (char_code),
        .cell_index     (cell_index),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .cursor_row_out (cursor_row_out),
        .cursor_col_out (cursor_col_out),
        .cell_data      (cell_data)
    );

    console_checker #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .op              (op),
        .char_code       (char_code),
        .cell_index      (cell_index),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .cursor_row_out  (cursor_row_out),
        .cursor_col_out  (cursor_col_out),
        .cell_data       (cell_data),
        .mismatches      (mismatches),
        .results_pending (results_pending)
    );

    // receiver back-pressure in bursts of random length
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end
        else if (idling_on && $urandom_range(0, 7) == 0)
        begin
            stall_left <= $urandom_range(0, 7);
            out_stall  <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    task automatic send_console_item(
        input logic              op_v,
        input logic [CHAR_W-1:0] ch,
        input logic [IDX_W-1:0]  idx
    );
        if (idling_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        op         <= op_v;
        char_code  <= ch;
        cell_index <= idx;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic put_char(input logic [CHAR_W-1:0] ch);
        send_console_item(OP_PUT, ch, IDX_W'($urandom_range(0, 2047)));
    endtask

    task automatic read_cell(input logic [IDX_W-1:0] idx);
        send_console_item(OP_READ, CHAR_W'($urandom_range(0, 255)), idx);
    endtask

    function automatic logic [CHAR_W-1:0] rand_glyph();
        logic [CHAR_W-1:0] g;
        g = CHAR_W'($urandom_range(0, 255));
        if (g == CH_NEWLINE || g == CH_BACKSPACE)
            g = CH_SPACE;
        return g;
    endfunction

    // hold the input idle until every result is back
    task automatic drain_console();
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_text_color(input logic [COLOR_W-1:0] color);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= color;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // mostly text lines of random length ending in newlines, with reads,
    // backspace runs and raw bytes mixed in
    task automatic run_console_text(input int n_items);
        int sent;
        int pick;
        int len;
        sent = 0;
        while (sent < n_items)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 12)
            begin
                if ($urandom_range(0, 3) == 0)
                    read_cell(IDX_W'($urandom_range(CELLS, 2047)));
                else
                    read_cell(IDX_W'($urandom_range(0, CELLS - 1)));
                sent++;
            end
            else if (pick < 20)
            begin
                put_char(CHAR_W'($urandom_range(0, 255)));
                sent++;
            end
            else if (pick < 28)
            begin
                len = $urandom_range(1, 4);
                repeat (len) put_char(CH_BACKSPACE);
                sent += len;
            end
            else
            begin
                pick = $urandom_range(0, 9);
                if (pick < 6)
                    len = $urandom_range(0, 3);
                else if (pick < 9)
                    len = $urandom_range(4, 30);
                else
                    len = $urandom_range(COLUMNS - 5, COLUMNS + 5);
                repeat (len) put_char(rand_glyph());
                sent += len;
                if ($urandom_range(0, 99) < 85)
                begin
                    put_char(CH_NEWLINE);
                    sent++;
                end
            end
        end
    endtask

    initial
    begin
        logic [COLOR_W-1:0] phase_colors [5];
        int waited;

        rst_n       <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        in_valid    <= 1'b0;
        op          <= OP_PUT;
        char_code   <= '0;
        cell_index  <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // wait out the clearing pass
        while (in_stall)
            @(posedge clk);

        // directed part, reset color
        read_cell(IDX_W'(0));
        read_cell(IDX_W'(CELLS - 1));
        read_cell(IDX_W'(CELLS));
        send_console_item(OP_READ, 8'hFF, 11'h7FF);
        put_char(CH_BACKSPACE);
        put_char(8'h00);
        put_char(8'hFF);
        put_char(8'h41);
        read_cell(IDX_W'(0));
        read_cell(IDX_W'(1));
        put_char(CH_BACKSPACE);
        read_cell(IDX_W'(2));
        put_char(CH_NEWLINE);
        put_char(CH_BACKSPACE);
        put_char(CH_NEWLINE);
        put_char(CH_NEWLINE);
        send_console_item(OP_READ, CH_NEWLINE, IDX_W'(0));
        send_console_item(OP_READ, CH_BACKSPACE, IDX_W'(1));

        phase_colors[0] = 8'h00;
        phase_colors[1] = 8'hFF;
        phase_colors[2] = COLOR_W'($urandom_range(0, 255));
        phase_colors[3] = COLOR_W'($urandom_range(0, 255));
        phase_colors[4] = 8'h1F;
        for (int p = 0; p < 5; p++)
        begin
            drain_console();
            write_text_color(phase_colors[p]);
            if (p == 4)
                idling_on <= 1'b0;
            put_char(8'h5A);
            read_cell(IDX_W'(0));
            run_console_text(PHASE_ITEMS);
        end

        in_valid <= 1'b0;
        waited = 0;
        @(posedge clk);
        while (results_pending != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (10) @(posedge clk);
        if (mismatches == 0 && results_pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #100ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule
